// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the modular exponentiation RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mexp_pkg.sv =====
// Shared constants and types for the modular exponentiation block.
// No dependencies; used by mexp_mulmod and modular_exponentiation_top.
`default_nettype none

package mexp_pkg;

	// Port width of every operand and of the result
	localparam int FIELD_WIDTH   = 32;
	// Default arithmetic width (operands are masked to this many low bits)
	localparam int OPERAND_WIDTH = 32;

	// Status of the shared modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mm_status_t;

endpackage

`default_nettype wire

// ===== rtl/mexp_mulmod.sv =====
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle, MSB first.
// Depends on mexp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mexp_mulmod #(
	parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [OPERAND_WIDTH-1:0] op_a,
	input  wire logic [OPERAND_WIDTH-1:0] op_b,
	input  wire logic [OPERAND_WIDTH-1:0] op_m,
	output mexp_pkg::mm_status_t          status,
	output logic      [OPERAND_WIDTH-1:0] result
);

	localparam int W  = OPERAND_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_sh_q;
	logic [W-1:0]  m_q;

	logic [W+1:0]  sum;
	logic [W+1:0]  m1;
	logic [W+1:0]  m2;
	logic [W-1:0]  r_nx;

	// One step: r = (2r + a*bit) mod m, with 2r + a*bit < 3m
	always_comb begin
		m1  = {2'b00, m_q};
		m2  = {1'b0, m_q, 1'b0};
		sum = ({2'b00, r_q} << 1) + (b_sh_q[W-1] ? {2'b00, a_q} : '0);
		if (sum >= m2) begin
			r_nx = W'(sum - m2);
		end else if (sum >= m1) begin
			r_nx = W'(sum - m1);
		end else begin
			r_nx = W'(sum);
		end
	end

	// Control: W steps after start, done pulses for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= '0;
			a_q    <= op_a;
			b_sh_q <= op_b;
			m_q    <= op_m;
		end else if (busy_q) begin
			r_q    <= r_nx;
			b_sh_q <= b_sh_q << 1;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign result      = r_q;

	`ASSERT_IMPL(a_res_reduced, clk, arst_n, done_q, r_q < m_q, "mulmod result not below modulus")
	`ASSERT_NEXT(a_last_step, clk, arst_n, busy_q && !start && cnt_q == CW'(1), done_q && !busy_q, "mulmod missed done")

endmodule

`default_nettype wire

// ===== rtl/modular_exponentiation_top.sv =====
// Modular exponentiation: power_result = base_value ^ exponent mod modulus.
// Depends on mexp_pkg, mexp_mulmod and assert_macros.svh.
//
// Input channel: in_valid / in_stall carry modulus, exponent, base_value.
// A beat is taken when in_valid is high and in_stall is low. in_stall is
// high from the accepted beat until the result has moved to the output
// register, so one item is worked on at a time.
// Output channel: out_valid / out_stall carry power_result and bad_modulus.
// The result sits in an output register; a new input beat is taken while
// it still waits for the receiver. If the receiver stalls, the next result
// waits in the sequencer and in_stall stays high.
// Steps: the base is reduced as 1 * base mod modulus while the leading-one
// search runs alongside it; then, for each exponent bit below the top set
// bit, a squaring, plus a multiply by the reduced base where that bit is
// set. A zero modulus or zero exponent skips the multiplier and goes
// straight to the finish state.
// Every product runs through one shared bit-serial multiplier, one bit
// per cycle; that unit sets the rate.
// Reset (arst_n low) returns the sequencer to idle and drops out_valid.
`default_nettype none
`include "assert_macros.svh"

module modular_exponentiation_top #(
	parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [mexp_pkg::FIELD_WIDTH-1:0] modulus,
	input  wire logic [mexp_pkg::FIELD_WIDTH-1:0] exponent,
	input  wire logic [mexp_pkg::FIELD_WIDTH-1:0] base_value,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [mexp_pkg::FIELD_WIDTH-1:0] power_result,
	output logic                                  bad_modulus
);

	localparam int W  = OPERAND_WIDTH;
	localparam int FW = mexp_pkg::FIELD_WIDTH;
	localparam int CW = $clog2(W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [W-1:0]  m_q;
	logic [W-1:0]  e_q;
	logic [W-1:0]  base_q;
	logic [W-1:0]  res_q;
	logic          bad_q;
	logic [CW-1:0] bits_q;
	logic [W-1:0]  op_a_q;
	logic [W-1:0]  op_b_q;
	logic          mm_start_q;
	logic          out_valid_q;
	logic [FW-1:0] power_result_q;
	logic          bad_modulus_q;

	logic [W-1:0]         in_m;
	logic [W-1:0]         in_e;
	logic [W-1:0]         in_b;
	mexp_pkg::mm_status_t mm_st;
	logic [W-1:0]         mm_res;
	logic                 reduce_done;

	assign in_m = modulus[W-1:0];
	assign in_e = exponent[W-1:0];
	assign in_b = base_value[W-1:0];

	// Shared multiplier
	mexp_mulmod #(
		.OPERAND_WIDTH(W)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start_q),
		.op_a  (op_a_q),
		.op_b  (op_b_q),
		.op_m  (m_q),
		.status(mm_st),
		.result(mm_res)
	);

	// Sequencer: leading-one search, base reduction, square-and-multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mm_start_q     <= 1'b0;
			out_valid_q    <= 1'b0;
			m_q            <= '0;
			e_q            <= '0;
			base_q         <= '0;
			res_q          <= '0;
			bad_q          <= 1'b0;
			bits_q         <= '0;
			op_a_q         <= '0;
			op_b_q         <= '0;
			power_result_q <= '0;
			bad_modulus_q  <= 1'b0;
		end else begin
			mm_start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						m_q    <= in_m;
						e_q    <= in_e;
						bits_q <= CW'(W - 1);
						bad_q  <= 1'b0;
						if (in_m == '0) begin
							res_q   <= '0;
							bad_q   <= 1'b1;
							state_q <= ST_FINISH;
						end else if (in_e == '0) begin
							res_q   <= W'(1);
							state_q <= ST_FINISH;
						end else begin
							// base mod m computed as 1 * base
							op_a_q     <= W'(1);
							op_b_q     <= in_b;
							mm_start_q <= 1'b1;
							state_q    <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (!e_q[W-1]) begin
						e_q    <= e_q << 1;
						bits_q <= bits_q - 1'b1;
					end
					if (mm_st.done) begin
						// leading one consumed: acc = reduced base
						base_q <= mm_res;
						e_q    <= e_q << 1;
						if (bits_q == '0) begin
							res_q   <= mm_res;
							state_q <= ST_FINISH;
						end else begin
							op_a_q     <= mm_res;
							op_b_q     <= mm_res;
							mm_start_q <= 1'b1;
							state_q    <= ST_SQUARE;
						end
					end
				end
				ST_SQUARE: begin
					if (mm_st.done) begin
						if (e_q[W-1]) begin
							op_a_q     <= mm_res;
							op_b_q     <= base_q;
							mm_start_q <= 1'b1;
							state_q    <= ST_MULT;
						end else begin
							e_q    <= e_q << 1;
							bits_q <= bits_q - 1'b1;
							if (bits_q == CW'(1)) begin
								res_q   <= mm_res;
								state_q <= ST_FINISH;
							end else begin
								op_a_q     <= mm_res;
								op_b_q     <= mm_res;
								mm_start_q <= 1'b1;
							end
						end
					end
				end
				ST_MULT: begin
					if (mm_st.done) begin
						e_q    <= e_q << 1;
						bits_q <= bits_q - 1'b1;
						if (bits_q == CW'(1)) begin
							res_q   <= mm_res;
							state_q <= ST_FINISH;
						end else begin
							op_a_q     <= mm_res;
							op_b_q     <= mm_res;
							mm_start_q <= 1'b1;
							state_q    <= ST_SQUARE;
						end
					end
				end
				ST_FINISH: begin
					// move into the output register once it is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						power_result_q <= FW'(res_q);
						bad_modulus_q  <= bad_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign power_result = power_result_q;
	assign bad_modulus  = bad_modulus_q;

	assign reduce_done = (state_q == ST_REDUCE) && mm_st.done;

	`ASSERT_IMPL(a_lead_one, clk, arst_n, reduce_done, e_q[W-1], "leading one not aligned")
	`ASSERT_IMPL(a_start_free, clk, arst_n, mm_start_q, !mm_st.busy, "multiplier busy at start")
	`ASSERT_IMPL(a_bad_zero, clk, arst_n, out_valid && bad_modulus, ~|power_result, "bad modulus")

endmodule

`default_nettype wire
